FILE: hw/rtl/tfn_pkg.sv
// tfn_pkg: shared types for the triangle face normal pipeline
// no dependencies

package tfn_pkg;

  typedef struct packed {
    logic valid;
    logic mesh_end;
    logic degen;
  } ctl_t;

  localparam int unsigned LANES = 3;

endpackage

FILE: hw/rtl/tfn_cross.sv
// tfn_cross: edge subtract, edge products and cross product terms (three stages)
// depends on tfn_pkg

module tfn_cross #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  tfn_pkg::ctl_t ctl_in,
  input  logic signed [COORD_BITS-1:0] va [3],
  input  logic signed [COORD_BITS-1:0] vb [3],
  input  logic signed [COORD_BITS-1:0] vc [3],
  output tfn_pkg::ctl_t ctl_out,
  output logic [2*(COORD_BITS+1)-1:0] n_mag [3],
  output logic n_neg [3]
);
  import tfn_pkg::*;

  localparam int unsigned EW = COORD_BITS + 1;
  localparam int unsigned MW = 2 * EW;
  localparam int unsigned CW = MW + 1;

  ctl_t ctl1, ctl2;
  logic signed [EW-1:0] e0 [3];
  logic signed [EW-1:0] e1 [3];
  logic signed [MW-1:0] prod [6];
  logic signed [CW-1:0] diff [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl1.valid <= 1'b0;
      ctl2.valid <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      ctl1.valid <= ctl_in.valid;
      ctl2.valid <= ctl1.valid;
      ctl_out.valid <= ctl2.valid;
    end
    ctl1.mesh_end <= ctl_in.mesh_end;
    ctl1.degen <= 1'b0;
    ctl2.mesh_end <= ctl1.mesh_end;
    ctl2.degen <= 1'b0;
    ctl_out.mesh_end <= ctl2.mesh_end;
    ctl_out.degen <= 1'b0;
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      e0[j] <= $signed({vb[j][COORD_BITS-1], vb[j]}) - $signed({va[j][COORD_BITS-1], va[j]});
      e1[j] <= $signed({vc[j][COORD_BITS-1], vc[j]}) - $signed({va[j][COORD_BITS-1], va[j]});
    end
  end

  always_ff @(posedge clk) begin
    prod[0] <= MW'(e0[1] * e1[2]);
    prod[1] <= MW'(e0[2] * e1[1]);
    prod[2] <= MW'(e0[2] * e1[0]);
    prod[3] <= MW'(e0[0] * e1[2]);
    prod[4] <= MW'(e0[0] * e1[1]);
    prod[5] <= MW'(e0[1] * e1[0]);
  end

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      diff[j] = $signed({prod[2*j][MW-1], prod[2*j]})
              - $signed({prod[2*j+1][MW-1], prod[2*j+1]});
    end
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      n_neg[j] <= diff[j][CW-1];
      n_mag[j] <= diff[j][CW-1] ? MW'(-diff[j]) : MW'(diff[j]);
    end
  end

endmodule

FILE: hw/rtl/tfn_square.sv
// tfn_square: squares of the cross terms from split products, and squared length
// depends on tfn_pkg

module tfn_square #(
  parameter int unsigned COORD_BITS = 16
) (
  input  logic clk,
  input  logic rst,
  input  tfn_pkg::ctl_t ctl_in,
  input  logic [2*(COORD_BITS+1)-1:0] n_mag [3],
  input  logic n_neg [3],
  output tfn_pkg::ctl_t ctl_out,
  output logic [4*(COORD_BITS+1)-1:0] sq [3],
  output logic [4*(COORD_BITS+1)+1:0] len2,
  output logic sq_neg [3]
);
  import tfn_pkg::*;

  localparam int unsigned MW = 2 * (COORD_BITS + 1);
  localparam int unsigned H  = MW / 2;
  localparam int unsigned HW = MW - H;
  localparam int unsigned SW = 2 * MW;
  localparam int unsigned LW = SW + 2;

  ctl_t ctla, ctlb;
  logic [2*HW-1:0] hh [3];
  logic [MW-1:0]   hl [3];
  logic [2*H-1:0]  ll [3];
  logic [SW-1:0]   sqb [3];
  logic nega [3];
  logic negb [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      ctla.valid <= 1'b0;
      ctlb.valid <= 1'b0;
      ctl_out.valid <= 1'b0;
    end else begin
      ctla.valid <= ctl_in.valid;
      ctlb.valid <= ctla.valid;
      ctl_out.valid <= ctlb.valid;
    end
    ctla.mesh_end <= ctl_in.mesh_end;
    ctla.degen <= 1'b0;
    ctlb.mesh_end <= ctla.mesh_end;
    ctlb.degen <= 1'b0;
    ctl_out.mesh_end <= ctlb.mesh_end;
    ctl_out.degen <= (sqb[0] == '0) && (sqb[1] == '0) && (sqb[2] == '0);
  end

  always_ff @(posedge clk) begin
    for (int j = 0; j < 3; j++) begin
      hh[j] <= n_mag[j][MW-1:H] * n_mag[j][MW-1:H];
      hl[j] <= n_mag[j][MW-1:H] * n_mag[j][H-1:0];
      ll[j] <= n_mag[j][H-1:0] * n_mag[j][H-1:0];
      nega[j] <= n_neg[j];
      sqb[j] <= (SW'(hh[j]) << (2 * H)) + (SW'(hl[j]) << (H + 1)) + SW'(ll[j]);
      negb[j] <= nega[j];
      sq[j] <= sqb[j];
      sq_neg[j] <= negb[j];
    end
    len2 <= LW'(sqb[0]) + LW'(sqb[1]) + LW'(sqb[2]);
  end

endmodule

FILE: hw/rtl/tfn_root_step.sv
// tfn_root_step: one result bit of the normalizing divide-by-root, three lanes
// depends on tfn_pkg

module tfn_root_step #(
  parameter int unsigned WW  = 101,
  parameter int unsigned QW  = 15,
  parameter int unsigned BIT = 0
) (
  input  logic clk,
  input  logic rst,
  input  tfn_pkg::ctl_t ctl_in,
  input  logic [WW-1:0] len2_in,
  input  logic [WW-1:0] r_in [3],
  input  logic [WW-1:0] p_in [3],
  input  logic [QW-1:0] q_in [3],
  input  logic neg_in [3],
  output tfn_pkg::ctl_t ctl_out,
  output logic [WW-1:0] len2_out,
  output logic [WW-1:0] r_out [3],
  output logic [WW-1:0] p_out [3],
  output logic [QW-1:0] q_out [3],
  output logic neg_out [3]
);
  import tfn_pkg::*;

  logic [WW-1:0] d [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d[j] = (p_in[j] << (BIT + 1)) + (len2_in << (2 * BIT));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_out.valid <= 1'b0;
    end else begin
      ctl_out.valid <= ctl_in.valid;
    end
    ctl_out.mesh_end <= ctl_in.mesh_end;
    ctl_out.degen <= ctl_in.degen;
    len2_out <= len2_in;
    for (int j = 0; j < 3; j++) begin
      neg_out[j] <= neg_in[j];
      if (r_in[j] >= d[j]) begin
        r_out[j] <= r_in[j] - d[j];
        p_out[j] <= p_in[j] + (len2_in << BIT);
        q_out[j] <= q_in[j] | (QW'(1) << BIT);
      end else begin
        r_out[j] <= r_in[j];
        p_out[j] <= p_in[j];
        q_out[j] <= q_in[j];
      end
    end
  end

endmodule

FILE: hw/rtl/triangle_face_normal.sv
// triangle_face_normal: unit face normal of a triangle, fully pipelined
// depends on tfn_pkg, tfn_cross, tfn_square, tfn_root_step
//
// One triangle may be started in every cycle; busy stays low. Each result
// appears with done high after the edge and cross product stages, the squares
// and squared length stages, one step per result bit in the restoring
// root-divide chain, and one output register. The receiver cannot stall, so
// every transaction leaves the pipeline on a fixed schedule in start order.

module triangle_face_normal #(
  parameter int unsigned COORD_BITS = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  logic signed [COORD_BITS-1:0] a_x,
  input  logic signed [COORD_BITS-1:0] a_y,
  input  logic signed [COORD_BITS-1:0] a_z,
  input  logic signed [COORD_BITS-1:0] b_x,
  input  logic signed [COORD_BITS-1:0] b_y,
  input  logic signed [COORD_BITS-1:0] b_z,
  input  logic signed [COORD_BITS-1:0] c_x,
  input  logic signed [COORD_BITS-1:0] c_y,
  input  logic signed [COORD_BITS-1:0] c_z,
  input  logic mesh_end,
  output logic done,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] norm_z,
  output logic degenerate,
  output logic mesh_end_out
);
  import tfn_pkg::*;

  localparam int unsigned F   = NORMAL_FRAC_BITS;
  localparam int unsigned EW  = COORD_BITS + 1;
  localparam int unsigned MW  = 2 * EW;
  localparam int unsigned SW  = 4 * EW;
  localparam int unsigned LW  = SW + 2;
  localparam int unsigned WW  = SW + 2 * F + 5;
  localparam int unsigned QW  = F + 1;
  localparam int unsigned OW  = F + 2;
  localparam int unsigned LAT = F + 8;

  ctl_t ctl_in, ctl_c, ctl_s, ctl_fin;
  logic [MW-1:0] n_mag [3];
  logic n_neg [3];
  logic [SW-1:0] sq [3];
  logic [LW-1:0] len2;
  logic sq_neg [3];

  ctl_t ctl_k [F+2];
  logic [WW-1:0] len2_k [F+2];
  logic [WW-1:0] r_k [F+2][3];
  logic [WW-1:0] p_k [F+2][3];
  logic [QW-1:0] q_k [F+2][3];
  logic neg_k [F+2][3];
  logic [OW-1:0] res [3];

  assign busy = 1'b0;

  assign ctl_in.valid = start;
  assign ctl_in.mesh_end = mesh_end;
  assign ctl_in.degen = 1'b0;

  tfn_cross #(.COORD_BITS(COORD_BITS)) u_cross (
    .clk, .rst,
    .ctl_in (ctl_in),
    .va ('{a_x, a_y, a_z}),
    .vb ('{b_x, b_y, b_z}),
    .vc ('{c_x, c_y, c_z}),
    .ctl_out (ctl_c),
    .n_mag (n_mag),
    .n_neg (n_neg)
  );

  tfn_square #(.COORD_BITS(COORD_BITS)) u_square (
    .clk, .rst,
    .ctl_in (ctl_c),
    .n_mag (n_mag),
    .n_neg (n_neg),
    .ctl_out (ctl_s),
    .sq (sq),
    .len2 (len2),
    .sq_neg (sq_neg)
  );

  always_comb begin
    ctl_k[0] = ctl_s;
    len2_k[0] = WW'(len2);
    for (int j = 0; j < 3; j++) begin
      r_k[0][j] = WW'(sq[j]) << (2 * F);
      p_k[0][j] = '0;
      q_k[0][j] = '0;
      neg_k[0][j] = sq_neg[j];
    end
  end

  for (genvar k = 0; k <= F; k++) begin : g_step
    tfn_root_step #(.WW(WW), .QW(QW), .BIT(F - k)) u_step (
      .clk, .rst,
      .ctl_in (ctl_k[k]),
      .len2_in (len2_k[k]),
      .r_in (r_k[k]),
      .p_in (p_k[k]),
      .q_in (q_k[k]),
      .neg_in (neg_k[k]),
      .ctl_out (ctl_k[k+1]),
      .len2_out (len2_k[k+1]),
      .r_out (r_k[k+1]),
      .p_out (p_k[k+1]),
      .q_out (q_k[k+1]),
      .neg_out (neg_k[k+1])
    );
  end

  always_comb begin
    ctl_fin = ctl_k[F+1];
    for (int j = 0; j < 3; j++) begin
      if (ctl_fin.degen) begin
        res[j] = '0;
      end else if (neg_k[F+1][j]) begin
        res[j] = OW'(-OW'(q_k[F+1][j]));
      end else begin
        res[j] = OW'(q_k[F+1][j]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ctl_fin.valid;
    end
    norm_x <= res[0];
    norm_y <= res[1];
    norm_z <= res[2];
    degenerate <= ctl_fin.degen;
    mesh_end_out <= ctl_fin.mesh_end;
  end

  a_latency: assert property (@(posedge clk) disable iff (rst) start |-> ##LAT done)
    else $error("result missing after fixed latency");

  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    (done && degenerate) |-> (norm_x == 0 && norm_y == 0 && norm_z == 0))
    else $error("degenerate triangle with nonzero normal");

  a_range: assert property (@(posedge clk) disable iff (rst)
    (done && !degenerate) |->
      (norm_x <= $signed(OW'(1) << F) && norm_x >= -$signed(OW'(1) << F) &&
       norm_y <= $signed(OW'(1) << F) && norm_y >= -$signed(OW'(1) << F) &&
       norm_z <= $signed(OW'(1) << F) && norm_z >= -$signed(OW'(1) << F)))
    else $error("normal component beyond unit length");

endmodule

FILE: tb/triangle_face_normal_tb.sv
// triangle_face_normal_tb: self-checking bench for the triangle face normal pipeline
// drives triangles through start/busy, predicts each unit normal in exact integer math
// depends on triangle_face_normal only

module triangle_face_normal_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 400000;

  typedef struct {
    logic signed [15:0] ax, ay, az, bx, by, bz, cx, cy, cz;
    logic               last;
    bit                 drain;
  } triangle_t;

  typedef struct {
    logic [15:0] nx, ny, nz;
    logic        degen;
    logic        last;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic signed [15:0] a_x = '0, a_y = '0, a_z = '0;
  logic signed [15:0] b_x = '0, b_y = '0, b_z = '0;
  logic signed [15:0] c_x = '0, c_y = '0, c_z = '0;
  logic mesh_end = 1'b0;
  logic done;
  logic signed [15:0] norm_x, norm_y, norm_z;
  logic degenerate, mesh_end_out;

  triangle_t pending_tris[$];
  normal_t   expected_normals[$];
  triangle_t driven_tri;
  int        gap_left = 0;
  int        mismatches = 0;
  int        cycles = 0;

  triangle_face_normal uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .a_x(a_x), .a_y(a_y), .a_z(a_z),
    .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .c_x(c_x), .c_y(c_y), .c_z(c_z),
    .mesh_end(mesh_end), .done(done),
    .norm_x(norm_x), .norm_y(norm_y), .norm_z(norm_z),
    .degenerate(degenerate), .mesh_end_out(mesh_end_out)
  );

  always #6 clk = ~clk;

  // largest q with q^2 * len2 <= n^2 * 2^28, signed like n
  function automatic logic [15:0] scaled_component(longint n, logic [127:0] len2);
    logic [127:0] mag, rhs, cand, q;
    mag = (n < 0) ? 128'(-n) : 128'(n);
    rhs = (mag * mag) << 28;
    q = '0;
    for (int b = 14; b >= 0; b--) begin
      cand = q | (128'd1 << b);
      if (cand * cand * len2 <= rhs) q = cand;
    end
    return (n < 0) ? -q[15:0] : q[15:0];
  endfunction

  function automatic normal_t face_normal(triangle_t t);
    longint e0x, e0y, e0z, e1x, e1y, e1z, n0, n1, n2;
    logic [127:0] m0, m1, m2, len2;
    normal_t r;
    e0x = longint'(t.bx) - longint'(t.ax);
    e0y = longint'(t.by) - longint'(t.ay);
    e0z = longint'(t.bz) - longint'(t.az);
    e1x = longint'(t.cx) - longint'(t.ax);
    e1y = longint'(t.cy) - longint'(t.ay);
    e1z = longint'(t.cz) - longint'(t.az);
    n0 = e0y * e1z - e0z * e1y;
    n1 = e0z * e1x - e0x * e1z;
    n2 = e0x * e1y - e0y * e1x;
    m0 = (n0 < 0) ? 128'(-n0) : 128'(n0);
    m1 = (n1 < 0) ? 128'(-n1) : 128'(n1);
    m2 = (n2 < 0) ? 128'(-n2) : 128'(n2);
    len2 = m0 * m0 + m1 * m1 + m2 * m2;
    r.last = t.last;
    if (len2 == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
    end else begin
      r.nx = scaled_component(n0, len2);
      r.ny = scaled_component(n1, len2);
      r.nz = scaled_component(n2, len2);
      r.degen = 1'b0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int sel;
    sel = $urandom_range(0, 19);
    if (sel < 12) return 0;
    if (sel < 18) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic triangle_t make_tri(int ax, int ay, int az, int bx, int by, int bz,
                                         int cx, int cy, int cz, bit last);
    triangle_t t;
    t.ax = 16'(ax); t.ay = 16'(ay); t.az = 16'(az);
    t.bx = 16'(bx); t.by = 16'(by); t.bz = 16'(bz);
    t.cx = 16'(cx); t.cy = 16'(cy); t.cz = 16'(cz);
    t.last = last;
    t.drain = 1'b0;
    return t;
  endfunction

  function automatic int near(int base, int spread);
    return base + $signed($urandom_range(0, 2 * spread)) - spread;
  endfunction

  function automatic triangle_t random_tri();
    triangle_t t;
    int kind, ox, oy, oz, s, dx, dy, dz;
    kind = $urandom_range(0, 19);
    t = make_tri($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom, $urandom_range(0, 7) == 0);
    ox = $signed(16'($urandom)); oy = $signed(16'($urandom)); oz = $signed(16'($urandom));
    s = 1 << $urandom_range(0, 10);
    if (kind >= 6 && kind < 15) begin
      // small triangle around a random point
      t.ax = 16'(ox); t.ay = 16'(oy); t.az = 16'(oz);
      t.bx = 16'(near(ox, s)); t.by = 16'(near(oy, s)); t.bz = 16'(near(oz, s));
      t.cx = 16'(near(ox, s)); t.cy = 16'(near(oy, s)); t.cz = 16'(near(oz, s));
    end else if (kind == 15 || kind == 16) begin
      // collinear: c = a + k*(b - a)
      dx = near(0, s); dy = near(0, s); dz = near(0, s);
      t.ax = 16'(ox); t.ay = 16'(oy); t.az = 16'(oz);
      t.bx = 16'(ox + dx); t.by = 16'(oy + dy); t.bz = 16'(oz + dz);
      t.cx = 16'(ox - 2 * dx); t.cy = 16'(oy - 2 * dy); t.cz = 16'(oz - 2 * dz);
    end else if (kind == 17) begin
      // flat in one axis plane
      t.az = 16'(oz); t.bz = 16'(oz); t.cz = 16'(oz);
    end else if (kind == 18) begin
      t.bx = t.ax; t.by = t.ay; t.bz = t.az;
    end
    return t;
  endfunction

  // driver
  always @(posedge clk) begin
    triangle_t nxt;
    logic go;
    cycles <= cycles + 1;
    if (rst) begin
      start <= 1'b0;
    end else begin
      go = 1'b0;
      if (start && !busy) begin
        expected_normals.push_back(face_normal(driven_tri));
        gap_left = pick_gap();
      end
      if (!(start && busy)) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_tris.size() > 0) begin
          if (!pending_tris[0].drain || expected_normals.size() == 0) begin
            nxt = pending_tris.pop_front();
            driven_tri = nxt;
            a_x <= nxt.ax; a_y <= nxt.ay; a_z <= nxt.az;
            b_x <= nxt.bx; b_y <= nxt.by; b_z <= nxt.bz;
            c_x <= nxt.cx; c_y <= nxt.cy; c_z <= nxt.cz;
            mesh_end <= nxt.last;
            go = 1'b1;
          end
        end
        start <= go;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    normal_t exp_n;
    if (!rst && done) begin
      if (expected_normals.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result transaction at cycle %0d", cycles);
      end else begin
        exp_n = expected_normals.pop_front();
        if (norm_x !== exp_n.nx || norm_y !== exp_n.ny || norm_z !== exp_n.nz ||
            degenerate !== exp_n.degen || mesh_end_out !== exp_n.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp %0d %0d %0d degen %b end %b, got %0d %0d %0d degen %b end %b",
                     $signed(exp_n.nx), $signed(exp_n.ny), $signed(exp_n.nz), exp_n.degen,
                     exp_n.last, norm_x, norm_y, norm_z, degenerate, mesh_end_out);
        end
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    triangle_t t;
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0, 1));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 1, 1, 0, 0, 1));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                                    -32768, 32767, -32768, 0));
    pending_tris.push_back(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                                    32767, -32768, 32767, 1));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 32767, 32767, 32767,
                                    32767, -32768, 32767, 0));
    pending_tris.push_back(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                                    -32768, -32768, 32767, 1));
    pending_tris.push_back(make_tri(1, 2, 3, 1, 2, 3, 7, 8, 9, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 1, 2, 2, 2, 1));
    pending_tris.push_back(make_tri(-32768, -32768, -32768, 0, 0, 0, 32767, 32767, 32767, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 0, 0, 0, 0, -1, 0));
    pending_tris.push_back(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1, 1));
    pending_tris.push_back(make_tri(5, -3, 100, 32767, 1, -32768, -2, 32767, 17, 0));
    for (int i = 0; i < 1450; i++) begin
      t = random_tri();
      t.drain = (i % 300 == 150);
      pending_tris.push_back(t);
    end
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    wait (pending_tris.size() == 0 && !start && expected_normals.size() == 0);
    repeat (40) @(posedge clk);
    if (mismatches == 0 && expected_normals.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end
endmodule
